// File: src/fri_pkg.sv
// Shared types, constants and the membership table builder for the fuzzy rule block.
`default_nettype none
package fri_pkg;

    localparam int RULES_DEF        = 16;
    localparam int MU_FRAC_BITS_DEF = 16;
    localparam int MU_W_MAX         = 25;
    localparam int ROM_DEPTH        = 256;
    localparam int DIV_STEPS        = 17;
    localparam int DIV_CNT_W        = 5;
    localparam int CFG_W            = 5;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;
    localparam logic JOIN_AND = 1'b0;
    localparam logic JOIN_OR  = 1'b1;

    localparam logic REG_RULE_COUNT = 1'b0;

    typedef struct packed {
        logic signed [7:0] eset;
        logic              join_or;
        logic signed [7:0] dset;
        logic signed [7:0] outv;
    } rule_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MEMB,
        ST_ACC,
        ST_DIV_INIT,
        ST_DIV,
        ST_FINISH
    } fri_state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic rd;
        logic memb;
        logic acc;
        logic div_init;
        logic div_step;
        logic finish;
    } fri_cmd_t;

    typedef logic [MU_W_MAX-1:0] mu_rom_t [ROM_DEPTH];

    // exp(-d*d/1800) via Q1.31 Taylor series of exp(-x/64), then six squarings
    function automatic mu_rom_t fri_build_rom(input int frac);
        mu_rom_t     rom;
        logic [63:0] dd;
        logic [63:0] t;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] v;
        for (int d = 0; d < ROM_DEPTH; d++) begin
            dd   = 64'(d) * 64'(d);
            t    = ((dd << 31) + 64'd57600) / 64'd115200;
            term = 64'd1 << 31;
            pos  = 64'd1 << 31;
            neg  = 64'd0;
            for (int k = 1; k <= 13; k++) begin
                term = ((term * t) >> 31) / 64'(k);
                if ((k % 2) == 1) begin
                    neg = neg + term;
                end else begin
                    pos = pos + term;
                end
            end
            v = pos - neg;
            for (int k = 0; k < 6; k++) begin
                v = (v * v + (64'd1 << 30)) >> 31;
            end
            rom[d] = MU_W_MAX'((v + (64'd1 << (30 - frac))) >> (31 - frac));
        end
        return rom;
    endfunction

endpackage
`default_nettype wire

// File: src/fuzzy_rule_inference.sv
// Top level: zero-order Sugeno fuzzy controller with loadable rules and config port.
//
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid / s_ready | action, rule fields, error, error_delta
//  m_      | out       | m_valid / m_ready | drive, valid_res
//  apb     | in        | psel/penable      | rule_count at byte address 0
//
// A load transfer writes the rule table and leaves the sequencer idle. An evaluate
// transfer runs table read, membership lookup and multiply-accumulate for each active
// rule, then divider init, the 17-step shift-subtract divider and the result load.
// One item is in work at a time. Reset is synchronous, active low, and
// clears the sequencer, the result valid and rule_count; the rule table is not cleared.
// The result register holds a finished result while m_ready is low; a following
// evaluation stalls in its finish state until that result is taken.
`default_nettype none
module fuzzy_rule_inference import fri_pkg::*; #(
    parameter int RULES        = RULES_DEF,
    parameter int MU_FRAC_BITS = MU_FRAC_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_action,
    input  wire logic [3:0]        s_rule_index,
    input  wire logic signed [7:0] s_rule_error_set,
    input  wire logic              s_rule_join,
    input  wire logic signed [7:0] s_rule_delta_set,
    input  wire logic signed [7:0] s_rule_output,
    input  wire logic signed [7:0] s_error,
    input  wire logic signed [7:0] s_error_delta,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic signed [15:0]     m_drive,
    output logic                   m_valid_res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int IDX_W = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int CNT_W = $clog2(RULES + 1);

    logic [CFG_W-1:0] rule_count_reg;
    logic [CNT_W-1:0] n_eff;
    fri_cmd_t         cmd;
    logic [IDX_W-1:0] rd_idx;
    logic             cfg_wr;

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_RULE_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rule_count_reg <= '0;
        end else if (cfg_wr) begin
            rule_count_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RULE_COUNT) ? 32'(rule_count_reg) : 32'd0;
    assign n_eff  = (int'(rule_count_reg) > RULES) ? CNT_W'(RULES) : CNT_W'(rule_count_reg);

    fri_ctrl #(
        .RULES (RULES),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .n_eff    (n_eff),
        .cmd      (cmd),
        .rd_idx   (rd_idx)
    );

    fri_datapath #(
        .RULES        (RULES),
        .MU_FRAC_BITS (MU_FRAC_BITS),
        .IDX_W        (IDX_W)
    ) u_datapath (
        .aclk             (aclk),
        .cmd              (cmd),
        .rd_idx           (rd_idx),
        .s_rule_index     (s_rule_index),
        .s_rule_error_set (s_rule_error_set),
        .s_rule_join      (s_rule_join),
        .s_rule_delta_set (s_rule_delta_set),
        .s_rule_output    (s_rule_output),
        .s_error          (s_error),
        .s_error_delta    (s_error_delta),
        .m_drive          (m_drive),
        .m_valid_res      (m_valid_res)
    );

    a_zero_weight_zero_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_valid_res) |-> (m_drive == 16'sd0))
        else $error("result without weight carries nonzero drive");

    a_eval_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_action == ACT_EVAL)) |=> !s_ready)
        else $error("evaluate transfer did not start a run");

    a_load_single_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_action == ACT_LOAD)) |=> s_ready)
        else $error("load transfer stalled the input");

    a_cfg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && (paddr[2] == REG_RULE_COUNT))
        |=> (rule_count_reg == $past(pwdata[CFG_W-1:0])))
        else $error("rule_count write lost");

endmodule
`default_nettype wire

// File: src/fri_ctrl.sv
// Sequencer: rule walk, division steps and result register handshake.
`default_nettype none
module fri_ctrl import fri_pkg::*; #(
    parameter int RULES = RULES_DEF,
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire logic             s_action,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    input  wire logic [CNT_W-1:0] n_eff,
    output fri_cmd_t              cmd,
    output logic [IDX_W-1:0]      rd_idx
);

    fri_state_t             state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [DIV_CNT_W-1:0]   step_reg, step_next;
    logic                   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        step_next    = step_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_action == ACT_LOAD) begin
                        cmd.load = 1'b1;
                    end else begin
                        cmd.start  = 1'b1;
                        idx_next   = '0;
                        state_next = (n_eff == '0) ? ST_DIV_INIT : ST_READ;
                    end
                end
            end
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = ST_MEMB;
            end
            ST_MEMB: begin
                cmd.memb   = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc = 1'b1;
                if (CNT_W'(idx_reg) + CNT_W'(1) == n_eff) begin
                    state_next = ST_DIV_INIT;
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + DIV_CNT_W'(1);
                if (step_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // wait until the result register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign rd_idx  = idx_reg;

endmodule
`default_nettype wire

// File: src/fri_datapath.sv
// Rule table, membership lookup, weighted sums and shift-subtract divider.
`default_nettype none
module fri_datapath import fri_pkg::*; #(
    parameter int RULES        = RULES_DEF,
    parameter int MU_FRAC_BITS = MU_FRAC_BITS_DEF,
    parameter int IDX_W        = 4
) (
    input  wire logic              aclk,
    input  wire fri_cmd_t          cmd,
    input  wire logic [IDX_W-1:0]  rd_idx,
    input  wire logic [3:0]        s_rule_index,
    input  wire logic signed [7:0] s_rule_error_set,
    input  wire logic              s_rule_join,
    input  wire logic signed [7:0] s_rule_delta_set,
    input  wire logic signed [7:0] s_rule_output,
    input  wire logic signed [7:0] s_error,
    input  wire logic signed [7:0] s_error_delta,
    output logic signed [15:0]     m_drive,
    output logic                   m_valid_res
);

    localparam int      MU_W   = MU_FRAC_BITS + 1;
    localparam int      PROD_W = MU_W + 9;
    localparam int      NUM_W  = PROD_W + 7;
    localparam int      DEN_W  = MU_W + 7;
    localparam int      CMP_W  = NUM_W + 9;
    localparam mu_rom_t MU_ROM = fri_build_rom(MU_FRAC_BITS);

    rule_t rule_mem [RULES];
    rule_t rd_reg;

    logic signed [7:0]        e_reg, de_reg;
    logic [MU_W-1:0]          mu_e_reg, mu_d_reg;
    logic                     join_reg;
    logic signed [7:0]        outv_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [CMP_W-1:0]         rem_reg;
    logic [CMP_W-1:0]         dsh_reg;
    logic [DIV_STEPS-1:0]     q_reg;
    logic                     neg_reg;
    logic signed [15:0]       drive_reg;
    logic                     vres_reg;

    logic signed [8:0]        diff_e, diff_d;
    logic [7:0]               abs_e, abs_d;
    logic [MU_W-1:0]          w;
    logic signed [PROD_W-1:0] prod;
    logic [NUM_W-1:0]         num_mag;
    logic                     ge;
    logic [15:0]              q_lo;

    always_ff @(posedge aclk) begin
        if (cmd.load && (int'(s_rule_index) < RULES)) begin
            rule_mem[IDX_W'(s_rule_index)] <= '{eset: s_rule_error_set, join_or: s_rule_join,
                                                 dset: s_rule_delta_set, outv: s_rule_output};
        end
        if (cmd.rd) begin
            rd_reg <= rule_mem[rd_idx];
        end
    end

    always_comb begin
        diff_e = 9'(e_reg) - 9'(rd_reg.eset);
        diff_d = 9'(de_reg) - 9'(rd_reg.dset);
        abs_e  = diff_e[8] ? 8'(-diff_e) : diff_e[7:0];
        abs_d  = diff_d[8] ? 8'(-diff_d) : diff_d[7:0];
        if (join_reg == JOIN_AND) begin
            w = (mu_e_reg < mu_d_reg) ? mu_e_reg : mu_d_reg;
        end else begin
            w = (mu_e_reg > mu_d_reg) ? mu_e_reg : mu_d_reg;
        end
        prod    = $signed({1'b0, w}) * outv_reg;
        num_mag = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
        ge      = rem_reg >= dsh_reg;
        q_lo    = q_reg[15:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            e_reg   <= s_error;
            de_reg  <= s_error_delta;
            num_reg <= '0;
            den_reg <= '0;
        end
        if (cmd.memb) begin
            mu_e_reg <= MU_ROM[abs_e][MU_W-1:0];
            mu_d_reg <= MU_ROM[abs_d][MU_W-1:0];
            join_reg <= rd_reg.join_or;
            outv_reg <= rd_reg.outv;
        end
        if (cmd.acc) begin
            num_reg <= num_reg + NUM_W'(prod);
            den_reg <= den_reg + DEN_W'(w);
        end
        if (cmd.div_init) begin
            // quotient magnitude stays below 2^17, so start at den << 16
            rem_reg <= CMP_W'({num_mag, 8'd0});
            dsh_reg <= CMP_W'(den_reg) << (DIV_STEPS - 1);
            q_reg   <= '0;
            neg_reg <= num_reg[NUM_W-1];
        end
        if (cmd.div_step) begin
            if (ge) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= {q_reg[DIV_STEPS-2:0], ge};
        end
        if (cmd.finish) begin
            vres_reg <= (den_reg != '0);
            if (den_reg == '0) begin
                drive_reg <= '0;
            end else begin
                drive_reg <= neg_reg ? $signed(-q_lo) : $signed(q_lo);
            end
        end
    end

    assign m_drive     = drive_reg;
    assign m_valid_res = vres_reg;

endmodule
`default_nettype wire
